// ===== rtl/ryuv_pkg.sv =====
// Package for the RGB to planar YUV 4:2:0 converter.
// Holds the port and job types, the frame limits and the back-end sequencer states.
// No dependencies.
package ryuv_pkg;

  localparam int unsigned MaxWidth     = 4096;
  localparam int unsigned MaxHeight    = 4096;
  localparam int unsigned DimWidth     = 13;
  localparam int unsigned CountWidth   = 12;
  localparam int unsigned AddrWidth    = 24;
  localparam int unsigned CfgIdxWidth  = 4;
  localparam int unsigned CfgDataWidth = 13;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [DimWidth-1:0] WidthReset  = 13'd640;
  localparam logic [DimWidth-1:0] HeightReset = 13'd480;

  localparam logic [CfgIdxWidth-1:0] RegImageWidth  = 4'd0;
  localparam logic [CfgIdxWidth-1:0] RegImageHeight = 4'd1;

  localparam logic [1:0] PlaneY = 2'd0;
  localparam logic [1:0] PlaneU = 2'd1;
  localparam logic [1:0] PlaneV = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [1:0]           plane;
    logic [AddrWidth-1:0] sample_address;
    logic [7:0]           sample_value;
    logic                 last_of_run;
    logic                 frame_done;
  } res_t;

  typedef struct packed {
    pix_t                 pix;
    logic [AddrWidth-1:0] luma_addr;
    logic [AddrWidth-1:0] chroma_addr;
    logic                 has_chroma;
    logic                 last_pixel;
  } job_t;

  typedef enum logic [1:0] {
    BkLoad,
    BkEmitY,
    BkEmitU,
    BkEmitV
  } back_state_e;

endpackage

// ===== rtl/ryuv_front.sv =====
// Front end: configuration registers, raster position and sample addresses.
// Classifies each accepted pixel into a job for the queue. Uses ryuv_pkg.
module ryuv_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [ryuv_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [ryuv_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                            push_i,
  input  ryuv_pkg::pix_t                  pixel_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output ryuv_pkg::job_t                  job_o
);

  logic [ryuv_pkg::DimWidth-1:0]   width_q, width_d, height_q, height_d;
  logic [ryuv_pkg::DimWidth-1:0]   w_eff, h_eff;
  logic [ryuv_pkg::CountWidth-1:0] col_q, col_d, row_q, row_d;
  logic [ryuv_pkg::AddrWidth-1:0]  luma_q, luma_d, cbase_q, cbase_d;
  logic                            col_last, row_last, cfg_hit;

  always_comb begin
    if (width_q < 13'd2) begin
      w_eff = 13'd2;
    end else if (width_q > ryuv_pkg::DimWidth'(ryuv_pkg::MaxWidth)) begin
      w_eff = ryuv_pkg::DimWidth'(ryuv_pkg::MaxWidth);
    end else begin
      w_eff = width_q;
    end
    if (height_q < 13'd2) begin
      h_eff = 13'd2;
    end else if (height_q > ryuv_pkg::DimWidth'(ryuv_pkg::MaxHeight)) begin
      h_eff = ryuv_pkg::DimWidth'(ryuv_pkg::MaxHeight);
    end else begin
      h_eff = height_q;
    end
  end

  assign col_last = ({1'b0, col_q} == w_eff - 13'd1);
  assign row_last = ({1'b0, row_q} == h_eff - 13'd1);
  assign q_push_o = push_i && !q_full_i;
  assign cfg_hit  = cfg_valid_i &&
                    (cfg_index_i == ryuv_pkg::RegImageWidth ||
                     cfg_index_i == ryuv_pkg::RegImageHeight);

  always_comb begin
    job_o.pix         = pixel_i;
    job_o.luma_addr   = luma_q;
    job_o.chroma_addr = cbase_q + ryuv_pkg::AddrWidth'(col_q >> 1);
    job_o.has_chroma  = !row_q[0] && !col_q[0];
    job_o.last_pixel  = col_last && row_last;
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    luma_d   = luma_q;
    cbase_d  = cbase_q;
    if (cfg_hit) begin
      if (cfg_index_i == ryuv_pkg::RegImageWidth) begin
        width_d = cfg_data_i;
      end else begin
        height_d = cfg_data_i;
      end
      col_d   = '0;
      row_d   = '0;
      luma_d  = '0;
      cbase_d = '0;
    end else if (q_push_o) begin
      if (col_last) begin
        col_d = '0;
        if (row_last) begin
          row_d   = '0;
          luma_d  = '0;
          cbase_d = '0;
        end else begin
          row_d  = row_q + 12'd1;
          luma_d = luma_q + 24'd1;
          if (row_q[0]) begin
            cbase_d = cbase_q + ryuv_pkg::AddrWidth'(w_eff >> 1);
          end
        end
      end else begin
        col_d  = col_q + 12'd1;
        luma_d = luma_q + 24'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ryuv_pkg::WidthReset;
      height_q <= ryuv_pkg::HeightReset;
      col_q    <= '0;
      row_q    <= '0;
      luma_q   <= '0;
      cbase_q  <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      luma_q   <= luma_d;
      cbase_q  <= cbase_d;
    end
  end

endmodule

// ===== rtl/ryuv_queue.sv =====
// Short job queue between the front end and the back end.
// Two entries of ryuv_pkg::job_t. Uses ryuv_pkg.
module ryuv_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ryuv_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ryuv_pkg::job_t job_o
);

  localparam int unsigned PtrWidth = $clog2(ryuv_pkg::QueueDepth);
  localparam int unsigned CntWidth = $clog2(ryuv_pkg::QueueDepth + 1);

  ryuv_pkg::job_t        mem_q [ryuv_pkg::QueueDepth];
  logic [PtrWidth-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == CntWidth'(ryuv_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? PtrWidth'(wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? PtrWidth'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntWidth'(ryuv_pkg::QueueDepth))
    else $error("queue count beyond depth");

endmodule

// ===== rtl/ryuv_back.sv =====
// Back end: luma and chroma arithmetic and the result sequencer.
// Pops jobs from ryuv_queue and fills the output register. Uses ryuv_pkg.
module ryuv_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  ryuv_pkg::job_t job_i,
  output logic           q_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ryuv_pkg::res_t result_o
);

  function automatic logic [7:0] chroma_sat(input logic [7:0] minu, input logic [7:0] luma,
                                            input logic [15:0] k);
    logic        neg;
    logic [7:0]  mag;
    logic [23:0] prod;
    logic [7:0]  scaled;
    logic [7:0]  res;
    neg    = minu < luma;
    mag    = neg ? luma - minu : minu - luma;
    prod   = 24'(mag) * 24'(k);
    scaled = prod[23:16];
    if (neg) begin
      res = (scaled > 8'd128) ? 8'd0 : 8'd128 - scaled;
    end else begin
      res = (scaled > 8'd127) ? 8'd255 : 8'd128 + scaled;
    end
    return res;
  endfunction

  ryuv_pkg::back_state_e state_q, state_d;
  ryuv_pkg::job_t        job_q;
  logic [7:0]            y_q, u_q, v_q, c_val;
  logic [23:0]           luma_sum;
  logic                  out_valid_q, out_valid_d, slot_free, emit;
  ryuv_pkg::res_t        out_q, emit_res;

  assign slot_free = !out_valid_q || pop_i;
  assign luma_sum  = 24'(job_i.pix.red) * 24'd19595 + 24'(job_i.pix.green) * 24'd38470 +
                     24'(job_i.pix.blue) * 24'd7471;
  assign c_val     = (state_q == ryuv_pkg::BkEmitY) ?
                     chroma_sat(job_q.pix.blue, y_q, 16'd37028) :
                     chroma_sat(job_q.pix.red, y_q, 16'd46727);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ryuv_pkg::BkLoad: begin
        if (!q_empty_i) state_d = ryuv_pkg::BkEmitY;
      end
      ryuv_pkg::BkEmitY: begin
        if (slot_free) state_d = job_q.has_chroma ? ryuv_pkg::BkEmitU : ryuv_pkg::BkLoad;
      end
      ryuv_pkg::BkEmitU: begin
        if (slot_free) state_d = ryuv_pkg::BkEmitV;
      end
      ryuv_pkg::BkEmitV: begin
        if (slot_free) state_d = ryuv_pkg::BkLoad;
      end
      default: state_d = ryuv_pkg::BkLoad;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    emit     = 1'b0;
    emit_res = '0;
    case (state_q)
      ryuv_pkg::BkLoad: begin
        q_pop_o = !q_empty_i;
      end
      ryuv_pkg::BkEmitY: begin
        emit                    = slot_free;
        emit_res.plane          = ryuv_pkg::PlaneY;
        emit_res.sample_address = job_q.luma_addr;
        emit_res.sample_value   = y_q;
        emit_res.last_of_run    = !job_q.has_chroma;
        emit_res.frame_done     = !job_q.has_chroma && job_q.last_pixel;
      end
      ryuv_pkg::BkEmitU: begin
        emit                    = slot_free;
        emit_res.plane          = ryuv_pkg::PlaneU;
        emit_res.sample_address = job_q.chroma_addr;
        emit_res.sample_value   = u_q;
      end
      ryuv_pkg::BkEmitV: begin
        emit                    = slot_free;
        emit_res.plane          = ryuv_pkg::PlaneV;
        emit_res.sample_address = job_q.chroma_addr;
        emit_res.sample_value   = v_q;
        emit_res.last_of_run    = 1'b1;
        emit_res.frame_done     = job_q.last_pixel;
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= job_i;
      y_q   <= luma_sum[23:16];
    end
    if (state_q == ryuv_pkg::BkEmitY) u_q <= c_val;
    if (state_q == ryuv_pkg::BkEmitU) v_q <= c_val;
    if (emit) out_q <= emit_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ryuv_pkg::BkLoad;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ryuv_pkg::BkEmitU || state_q == ryuv_pkg::BkEmitV) |-> job_q.has_chroma)
    else $error("chroma emitted for a pixel without chroma");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_done) |-> out_q.last_of_run)
    else $error("frame end not on the last result of a pixel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.plane == ryuv_pkg::PlaneU) |-> !out_q.last_of_run)
    else $error("U sample marked as last of run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> ($stable(out_q) && out_valid_q))
    else $error("waiting result overwritten");

endmodule

// ===== rtl/rgb_to_yuv420_planar.sv =====
// RGB to planar YUV 4:2:0 converter, top level.
// Instantiates ryuv_front, ryuv_queue and ryuv_back. Uses ryuv_pkg.
//
// Pixels enter in raster order through a queue-style port (push/full) and
// results leave through another (empty/pop). Every pixel gives a luma sample;
// a pixel on an even row and even column also gives U and V, in the order Y,
// U, V. The back-end sequencer sets the rate: a pixel passes a load state and
// then one emit state per result; the next pixel loads only after the last
// result of the one before. A two-entry job queue and the output register let
// input and output stall independently. A width or height write restarts the
// frame at row 0, column 0; cfg_ready_o is always high.
module rgb_to_yuv420_planar (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ryuv_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [ryuv_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                              push,
  output logic                              full,
  input  ryuv_pkg::pix_t                    pixel_i,
  output logic                              empty,
  input  logic                              pop,
  output ryuv_pkg::res_t                    result_o
);

  logic           q_push, q_full, q_pop, q_empty;
  ryuv_pkg::job_t front_job, back_job;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;

  ryuv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .pixel_i     (pixel_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .job_o       (front_job)
  );

  ryuv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (back_job)
  );

  ryuv_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .job_i     (back_job),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .result_o  (result_o)
  );

endmodule
